/* rtl/rip_pkg.sv */
`timescale 1ns / 1ps
// Request id pool: shared constants, operation and result codes.
package rip_pkg;

  localparam int CAPACITY = 128;
  localparam int ID_W     = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FUNC_W   = 2;
  localparam int REQ_W    = 8;
  localparam int STAT_W   = 8;
  localparam int RC_W     = 3;
  // per-id metadata: {ready, status}
  localparam int META_W   = STAT_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_COMPLETE = 2'd1,
    FUNC_WAIT     = 2'd2,
    FUNC_CANCEL   = 2'd3
  } func_e;

  typedef enum logic [RC_W-1:0] {
    RC_OK        = 3'd0,
    RC_INVALID   = 3'd1,
    RC_FLUSHED   = 3'd2,
    RC_FULL      = 3'd3,
    RC_NOT_READY = 3'd4
  } rc_e;

endpackage

/* rtl/rip_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
module rip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/request_id_pool.sv */
`timescale 1ns / 1ps
// Request id pool: free-id stack with per-id in-use, ready and status marks.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one operation per transfer:
//   func_i selects allocate, complete, wait or cancel; req_id_i and
//   done_status_i are the operands. Every operation produces exactly one
//   result transfer on the output channel (out_valid_o / out_ready_i) with
//   result_code_o, issued_id_o and req_status_o.
//   Each item is held in the input register (work stage), its result in the output
//   register. One item is accepted every cycle while no result stalls; the work
//   stage computes the whole operation against the id stack RAM and the metadata
//   RAM, whose registered reads are issued at the input transfer. Same-cycle
//   writes to the addresses being read are forwarded through bypass registers.
//   Backpressure: a result waits in the output register; the work stage
//   holds its item while that register is full and not taken, and
//   in_ready_o drops only then. Nothing is lost or dropped.
//   Reset: asynchronous, active low. Pool empty of issued ids, stack reads
//   as ids 0..CAPACITY-1 through per-entry valid bits (no clearing pass);
//   the block takes items in the first cycle after reset.
module request_id_pool (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rip_pkg::FUNC_W-1:0]  func_i,
  input  logic [rip_pkg::REQ_W-1:0]   req_id_i,
  input  logic [rip_pkg::STAT_W-1:0]  done_status_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rip_pkg::RC_W-1:0]    result_code_o,
  output logic [rip_pkg::ID_W-1:0]    issued_id_o,
  output logic [rip_pkg::STAT_W-1:0]  req_status_o
);
  import rip_pkg::*;

  // handshake
  logic in_xfer;
  logic commit;

  // work stage (input register)
  logic              s1_valid_q;
  func_e             s1_func_q;
  logic [REQ_W-1:0]  s1_id_q;
  logic [STAT_W-1:0] s1_done_q;

  // read forwarding, captured with the RAM reads
  logic              meta_hit_q;
  logic [META_W-1:0] meta_byp_q;
  logic              stk_hit_q;
  logic [ID_W-1:0]   stk_byp_q;
  logic              stk_vld_q;
  logic [ID_W-1:0]   stk_idx_q;

  // pool state
  logic [CNT_W-1:0]  used_count_q, used_count_d;
  logic [CAPACITY-1:0] in_use_q;
  logic [CAPACITY-1:0] stk_written_q;

  // output register
  logic              out_valid_q;
  rc_e               rc_q;
  logic [ID_W-1:0]   issued_q;
  logic [STAT_W-1:0] status_q;

  // RAM ports
  logic              meta_we;
  logic [ID_W-1:0]   meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [ID_W-1:0]   meta_raddr;
  logic [META_W-1:0] meta_rdata;
  logic              stk_we;
  logic [ID_W-1:0]   stk_waddr;
  logic [ID_W-1:0]   stk_raddr;
  logic [ID_W-1:0]   stk_rdata;

  // work stage decode
  logic              id_ok;
  logic [ID_W-1:0]   slot;
  logic              busy;
  logic [META_W-1:0] meta;
  logic              is_ready;
  logic [ID_W-1:0]   top_id;
  logic              do_alloc;
  logic              do_push;
  logic              meta_wr;
  rc_e               rc_d;
  logic [ID_W-1:0]   issued_d;
  logic [STAT_W-1:0] status_d;
  logic              stk_hit;
  logic              meta_hit;

  assign commit     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || commit;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign id_ok    = {1'b0, s1_id_q} < (REQ_W + 1)'(CAPACITY);
  assign slot     = s1_id_q[ID_W-1:0];
  assign busy     = id_ok && in_use_q[slot];
  assign meta     = meta_hit_q ? meta_byp_q : meta_rdata;
  assign is_ready = meta[META_W-1];
  // stack entries never pushed still hold their reset id
  assign top_id   = stk_hit_q ? stk_byp_q : (stk_vld_q ? stk_rdata : stk_idx_q);

  always_comb begin
    rc_d       = RC_OK;
    issued_d   = '0;
    status_d   = '0;
    do_alloc   = 1'b0;
    do_push    = 1'b0;
    meta_wr    = 1'b0;
    meta_waddr = slot;
    meta_wdata = '0;
    case (s1_func_q)
      FUNC_ALLOC: begin
        if (used_count_q >= CNT_W'(CAPACITY)) begin
          rc_d = RC_FULL;
        end else begin
          do_alloc   = 1'b1;
          issued_d   = top_id;
          meta_wr    = 1'b1;
          meta_waddr = top_id;
        end
      end
      FUNC_COMPLETE: begin
        if (!busy) begin
          rc_d = RC_INVALID;
        end else begin
          meta_wr    = 1'b1;
          meta_wdata = {1'b1, s1_done_q};
        end
      end
      FUNC_WAIT: begin
        if (!busy) begin
          rc_d = RC_INVALID;
        end else if (!is_ready) begin
          rc_d = RC_NOT_READY;
        end else begin
          status_d = meta[STAT_W-1:0];
          do_push  = 1'b1;
        end
      end
      FUNC_CANCEL: begin
        if (!busy) begin
          rc_d = RC_INVALID;
        end else begin
          if (is_ready) begin
            rc_d = RC_FLUSHED;
          end
          do_push = 1'b1;
        end
      end
      default: begin
        rc_d = RC_INVALID;
      end
    endcase
  end

  // stack pointer and push write
  always_comb begin
    used_count_d = used_count_q;
    stk_we       = 1'b0;
    stk_waddr    = used_count_q[ID_W-1:0] - ID_W'(1);
    if (commit && do_alloc) begin
      used_count_d = used_count_q + CNT_W'(1);
    end else if (commit && do_push && (used_count_q != '0)) begin
      used_count_d = used_count_q - CNT_W'(1);
      stk_we       = 1'b1;
    end
  end

  assign meta_we    = commit && meta_wr;
  // next item reads the stack top as it stands after this commit
  assign stk_raddr  = used_count_d[ID_W-1:0];
  assign meta_raddr = req_id_i[ID_W-1:0];
  assign stk_hit    = stk_we && (stk_waddr == stk_raddr);
  assign meta_hit   = meta_we && (meta_waddr == meta_raddr);

  rip_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (slot),
    .re_i    (in_xfer),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  rip_ram #(
    .WIDTH (META_W),
    .DEPTH (CAPACITY)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (in_xfer),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      used_count_q  <= '0;
      in_use_q      <= '0;
      stk_written_q <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      used_count_q <= used_count_d;
      if (commit && do_alloc) begin
        in_use_q[top_id] <= 1'b1;
      end
      if (commit && do_push) begin
        in_use_q[slot] <= 1'b0;
      end
      if (stk_we) begin
        stk_written_q[stk_waddr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q  <= func_e'(func_i);
      s1_id_q    <= req_id_i;
      s1_done_q  <= done_status_i;
      meta_hit_q <= meta_hit;
      meta_byp_q <= meta_wdata;
      stk_hit_q  <= stk_hit;
      stk_byp_q  <= slot;
      stk_vld_q  <= stk_hit || stk_written_q[stk_raddr];
      stk_idx_q  <= stk_raddr;
    end
    if (commit) begin
      rc_q     <= rc_d;
      issued_q <= issued_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = rc_q;
  assign issued_id_o   = issued_q;
  assign req_status_o  = status_q;

  // stack pointer never passes the pool size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= CNT_W'(CAPACITY))
    else $error("stack pointer beyond capacity");

  // issued ids and in-use marks stay in step
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use_q) == 32'(used_count_q))
    else $error("in-use marks disagree with stack pointer");

  // an allocated id is marked in use after the commit
  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && do_alloc |=> in_use_q[$past(top_id)])
    else $error("allocated id not marked in use");

  // pool_full only when every id is out
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (rc_d == RC_FULL) |-> used_count_q == CNT_W'(CAPACITY))
    else $error("pool_full with free ids left");

  // a non-ok result carries no issued id
  a_issued_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (rc_q != RC_OK) |-> issued_q == '0)
    else $error("issued id on failed result");

endmodule

/* tb/request_id_pool_checker.sv */
`timescale 1ns / 1ps
// Request id pool checker: watches both channels, predicts each result and compares.
module request_id_pool_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [rip_pkg::FUNC_W-1:0]   func_i,
  input  logic [rip_pkg::REQ_W-1:0]    req_id_i,
  input  logic [rip_pkg::STAT_W-1:0]   done_status_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [rip_pkg::RC_W-1:0]     result_code_i,
  input  logic [rip_pkg::ID_W-1:0]     issued_id_i,
  input  logic [rip_pkg::STAT_W-1:0]   req_status_i,
  output logic [rip_pkg::CAPACITY-1:0] in_use_o,
  output logic [rip_pkg::CAPACITY-1:0] ready_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           fail_count_o
);
  import rip_pkg::*;

  typedef struct packed {
    rc_e               rc;
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] status;
  } outcome_t;

  // shadow of the pool
  logic [ID_W-1:0]   free_stack [CAPACITY];
  int unsigned       issued_cnt;
  logic [CAPACITY-1:0] owned;
  logic [CAPACITY-1:0] done_mark;
  logic [STAT_W-1:0] saved_status [CAPACITY];

  outcome_t outcome_q [$];
  int       fails;
  int       checked;

  function automatic void clear_pool();
    for (int i = 0; i < CAPACITY; i++) begin
      free_stack[i]   = i[ID_W-1:0];
      saved_status[i] = '0;
    end
    owned      = '0;
    done_mark  = '0;
    issued_cnt = 0;
  endfunction

  function automatic void release_id(int idx);
    owned[idx] = 1'b0;
    // stack pointer guarded, cannot underflow while an id is in use
    if (issued_cnt > 0) begin
      issued_cnt--;
      free_stack[issued_cnt] = idx[ID_W-1:0];
    end
  endfunction

  function automatic outcome_t apply_op(func_e op, logic [REQ_W-1:0] id,
                                        logic [STAT_W-1:0] status);
    outcome_t o;
    int       idx;
    logic [ID_W-1:0] got;
    o   = '{rc: RC_OK, id: '0, status: '0};
    idx = int'(id);
    if (op == FUNC_ALLOC) begin
      if (issued_cnt >= CAPACITY) begin
        o.rc = RC_FULL;
      end else begin
        got = free_stack[issued_cnt];
        issued_cnt++;
        owned[got]        = 1'b1;
        done_mark[got]    = 1'b0;
        saved_status[got] = '0;
        o.id = got;
      end
    end else if (idx >= CAPACITY || !owned[idx]) begin
      o.rc = RC_INVALID;
    end else begin
      case (op)
        FUNC_COMPLETE: begin
          done_mark[idx]    = 1'b1;
          saved_status[idx] = status;
        end
        FUNC_WAIT: begin
          if (!done_mark[idx]) begin
            o.rc = RC_NOT_READY;
          end else begin
            o.status = saved_status[idx];
            release_id(idx);
          end
        end
        default: begin
          if (done_mark[idx]) o.rc = RC_FLUSHED;
          release_id(idx);
        end
      endcase
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      clear_pool();
      outcome_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        outcome_q.push_back(apply_op(func_e'(func_i), req_id_i, done_status_i));
      end
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (outcome_q.size() == 0) begin
          $error("result transfer with nothing expected: result_code %0d", result_code_i);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          check_field("result_code", 8'(want.rc), 8'(result_code_i));
          check_field("issued_id", 8'(want.id), 8'(issued_id_i));
          check_field("req_status", want.status, req_status_i);
        end
      end
    end
    in_use_o     <= owned;
    ready_o      <= done_mark;
    pending_o    <= outcome_q.size();
    checked_o    <= checked;
    fail_count_o <= fails;
  end

endmodule

/* tb/request_id_pool_tb.sv */
`timescale 1ns / 1ps
// Request id pool testbench top: clock, reset, stimulus, result drain and verdict.
module request_id_pool_tb;
  import rip_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;

  // input channel, driven at the rising edge
  logic              in_valid = 1'b0;
  logic              in_ready;
  func_e             func = FUNC_ALLOC;
  logic [REQ_W-1:0]  req_id = '0;
  logic [STAT_W-1:0] done_status = '0;

  // output channel
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RC_W-1:0]   result_code;
  logic [ID_W-1:0]   issued_id;
  logic [STAT_W-1:0] req_status;

  // views handed back by the checker (registered, so reads at the edge are stable)
  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY-1:0] id_ready;
  int                  pending;
  int                  checked;
  int                  fails;

  // calm = no idling on either side; toggled now and then to get back-to-back stretches
  bit                  calm = 1'b0;
  int                  op_count [4];

  always #5 clk_i = ~clk_i;

  request_id_pool DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .req_id_i      (req_id),
    .done_status_i (done_status),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_code_o (result_code),
    .issued_id_o   (issued_id),
    .req_status_o  (req_status)
  );

  request_id_pool_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .req_id_i      (req_id),
    .done_status_i (done_status),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .result_code_i (result_code),
    .issued_id_i   (issued_id),
    .req_status_i  (req_status),
    .in_use_o      (in_use),
    .ready_o       (id_ready),
    .pending_o     (pending),
    .checked_o     (checked),
    .fail_count_o  (fails)
  );

  // One input transfer. Valid drops only when a gap is drawn, so a back-to-back
  // item never sees valid lowered and raised in the same step.
  task automatic send_op(func_e op, logic [REQ_W-1:0] id, logic [STAT_W-1:0] status);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    func        <= op;
    req_id      <= id;
    done_status <= status;
    do @(posedge clk_i); while (!in_ready);
    op_count[op]++;
  endtask

  // Hold the sender until every expected result has come back.
  // Valid drops first so the last item is not sent again while waiting.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random operation. Mostly well-formed traffic on ids currently in use,
  // with some noise: random op on a random id (possibly out of range, or free).
  task automatic random_op(int alloc_pct);
    int              r;
    int              k;
    logic [ID_W-1:0] live [$];
    logic [REQ_W-1:0] id;
    func_e           op;
    r = $urandom_range(0, 99);
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_use[i]) live.push_back(i[ID_W-1:0]);
    end
    if (r >= 92) begin
      op = func_e'($urandom_range(0, 3));
      id = REQ_W'($urandom_range(0, 255));
    end else if (r < alloc_pct || live.size() == 0) begin
      op = FUNC_ALLOC;
      id = REQ_W'($urandom_range(0, 255));
    end else begin
      id = REQ_W'(live[$urandom_range(0, live.size() - 1)]);
      k  = $urandom_range(0, 99);
      if (!id_ready[id]) begin
        // not complete yet: usually complete it, sometimes wait early or cancel
        op = (k < 55) ? FUNC_COMPLETE : (k < 70) ? FUNC_WAIT : FUNC_CANCEL;
      end else begin
        // complete: collect it, or complete again, or cancel after the flush
        op = (k < 70) ? FUNC_WAIT : (k < 85) ? FUNC_COMPLETE : FUNC_CANCEL;
      end
    end
    send_op(op, id, STAT_W'($urandom_range(0, 255)));
  endtask

  // Result side: random stall before each result, none while calm.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase_len [6];
    int phase_pct [6];
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    // --- directed: fresh pool, so the issued ids are known in advance ---
    // bad ids before anything is allocated, top bit of req_id included
    send_op(FUNC_WAIT, 8'd0, 8'h00);
    send_op(FUNC_CANCEL, 8'd127, 8'h00);
    send_op(FUNC_COMPLETE, 8'd255, 8'hFF);
    send_op(FUNC_WAIT, 8'd128, 8'h00);
    // id 0: early wait, double complete (status overwritten), then collect
    send_op(FUNC_ALLOC, 8'd0, 8'h00);
    send_op(FUNC_WAIT, 8'd0, 8'h00);
    send_op(FUNC_COMPLETE, 8'd0, 8'h00);
    send_op(FUNC_COMPLETE, 8'd0, 8'hFF);
    send_op(FUNC_WAIT, 8'd0, 8'h00);
    // cancel before completion, cancel after completion, cancel of a freed id
    send_op(FUNC_ALLOC, 8'd0, 8'h00);
    send_op(FUNC_ALLOC, 8'd0, 8'h00);
    send_op(FUNC_CANCEL, 8'd0, 8'h00);
    send_op(FUNC_COMPLETE, 8'd1, 8'h5A);
    send_op(FUNC_CANCEL, 8'd1, 8'h00);
    send_op(FUNC_CANCEL, 8'd1, 8'h00);
    // the stack now hands ids back in reverse of the order they were freed
    send_op(FUNC_ALLOC, 8'd0, 8'h00);
    send_op(FUNC_ALLOC, 8'd0, 8'h00);
    send_op(FUNC_COMPLETE, 8'd0, 8'hA5);
    send_op(FUNC_WAIT, 8'd0, 8'h00);
    wait_drained();
    send_op(FUNC_WAIT, 8'd1, 8'h00);
    send_op(FUNC_CANCEL, 8'd1, 8'h00);
    send_op(FUNC_WAIT, 8'd1, 8'h00);

    // --- random: fill (runs into pool full), drain, balanced, twice over ---
    phase_len = '{250, 150, 200, 250, 200, 150};
    phase_pct = '{80, 10, 35, 80, 10, 35};
    for (int p = 0; p < 6; p++) begin
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
        random_op(phase_pct[p]);
      end
      // after every second phase the sender holds off until the pool has answered everything
      if (p % 2 == 1) wait_drained();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d operations: %0d allocate, %0d complete, %0d wait, %0d cancel.",
             op_count[FUNC_ALLOC] + op_count[FUNC_COMPLETE] + op_count[FUNC_WAIT] +
             op_count[FUNC_CANCEL], op_count[FUNC_ALLOC], op_count[FUNC_COMPLETE],
             op_count[FUNC_WAIT], op_count[FUNC_CANCEL]);
    $display("%0d results compared over fill-heavy, drain-heavy and mixed phases.",
             checked);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
